/* rtl/cip_pkg.sv */
// Shared types and constants for the coalescing impact queue.
// Used by every module of the block except cip_ram; no dependencies of its own.
package cip_pkg;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_POP     = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP
  } back_state_t;

  // floor(mm / 350): bias to a nonnegative value, multiply by reciprocal
  localparam logic [24:0] CELL_BIAS_MM = 25'd8388800;  // 350 * 23968
  localparam logic [16:0] CELL_BIAS_Q  = 17'd23968;
  localparam logic [24:0] CELL_RECIP   = 25'd24542671; // ceil(2^33 / 350)
  localparam int          CELL_SHIFT   = 33;

  typedef struct packed {
    logic [63:0]        src_id;
    logic [63:0]        tgt_id;
    logic [63:0]        col_id;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic signed [31:0] impulse;
    logic signed [31:0] speed;
    logic [63:0]        low_key;
    logic [63:0]        high_key;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic signed [15:0] cell_z;
  } entry_t;

  typedef struct packed {
    cmd_t   command;
    entry_t entry;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic               pop_valid;
    logic [63:0]        src_id;
    logic [63:0]        tgt_id;
    logic [63:0]        col_id;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic signed [31:0] impulse;
    logic signed [31:0] speed;
    logic [4:0]         entry_count;
  } result_t;

endpackage

/* rtl/cip_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* rtl/cip_front.sv */
// Front end: accepts words, computes the pair key and spatial cells.
// Depends on cip_pkg.
module cip_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cip_pkg::cmd_t        in_command,
  input  logic [63:0]          in_src_id,
  input  logic [63:0]          in_tgt_id,
  input  logic [63:0]          in_col_id,
  input  logic signed [23:0]   in_point_x,
  input  logic signed [23:0]   in_point_y,
  input  logic signed [23:0]   in_point_z,
  input  logic signed [31:0]   in_impulse,
  input  logic signed [31:0]   in_speed,
  output logic                 push,
  input  logic                 push_ready,
  output cip_pkg::item_t       push_item
);
  import cip_pkg::*;

  logic        s1_valid;
  cmd_t        s1_cmd;
  logic [63:0] s1_src, s1_tgt, s1_col;
  logic signed [23:0] s1_px, s1_py, s1_pz;
  logic signed [31:0] s1_imp, s1_spd;
  logic [49:0] s1_prod_x, s1_prod_y, s1_prod_z;

  logic [24:0] bias_x, bias_y, bias_z;
  logic [63:0] partner;
  logic        take;

  assign bias_x = {in_point_x[23], in_point_x} + CELL_BIAS_MM;
  assign bias_y = {in_point_y[23], in_point_y} + CELL_BIAS_MM;
  assign bias_z = {in_point_z[23], in_point_z} + CELL_BIAS_MM;

  assign push     = s1_valid;
  assign in_ready = !s1_valid || push_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (push_ready) begin
      s1_valid <= 1'b0;
    end
    if (take) begin
      s1_cmd    <= in_command;
      s1_src    <= in_src_id;
      s1_tgt    <= in_tgt_id;
      s1_col    <= in_col_id;
      s1_px     <= in_point_x;
      s1_py     <= in_point_y;
      s1_pz     <= in_point_z;
      s1_imp    <= in_impulse;
      s1_spd    <= in_speed;
      s1_prod_x <= bias_x * CELL_RECIP;
      s1_prod_y <= bias_y * CELL_RECIP;
      s1_prod_z <= bias_z * CELL_RECIP;
    end
  end

  assign partner = (s1_tgt != 64'd0) ? s1_tgt : s1_col;

  always_comb begin
    push_item               = '0;
    push_item.command       = s1_cmd;
    push_item.entry.src_id  = s1_src;
    push_item.entry.tgt_id  = s1_tgt;
    push_item.entry.col_id  = s1_col;
    push_item.entry.point_x = s1_px;
    push_item.entry.point_y = s1_py;
    push_item.entry.point_z = s1_pz;
    push_item.entry.impulse = s1_imp;
    push_item.entry.speed   = s1_spd;
    if ($signed(partner) < $signed(s1_src)) begin
      push_item.entry.low_key  = partner;
      push_item.entry.high_key = s1_src;
    end else begin
      push_item.entry.low_key  = s1_src;
      push_item.entry.high_key = partner;
    end
    push_item.entry.cell_x = 16'(s1_prod_x[49:CELL_SHIFT] - CELL_BIAS_Q);
    push_item.entry.cell_y = 16'(s1_prod_y[49:CELL_SHIFT] - CELL_BIAS_Q);
    push_item.entry.cell_z = 16'(s1_prod_z[49:CELL_SHIFT] - CELL_BIAS_Q);
  end
endmodule

/* rtl/cip_fifo.sv */
// Two-word queue between front and back ends.
// Depends on cip_pkg.
module cip_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  output logic           wr_ready,
  input  cip_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_en,
  output cip_pkg::item_t rd_item
);
  import cip_pkg::*;

  item_t      slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_wr, do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = slots[rd_ptr];
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end
endmodule

/* rtl/cip_back.sv */
// Back end: sequencer over the entry RAM that merges, appends, pops and clears.
// Depends on cip_pkg and cip_ram; holds the output register.
module cip_back #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [4:0]       cfg_wdata,
  input  logic             item_valid,
  output logic             item_pop,
  input  cip_pkg::item_t   item,
  output logic             out_valid,
  input  logic             out_ready,
  output cip_pkg::result_t out_result
);
  import cip_pkg::*;

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  back_state_t state, state_next;
  item_t       cur, cur_next;
  logic [IW-1:0] head, head_next;
  logic [CW-1:0] occ, occ_next;
  logic [CW-1:0] rd_i, rd_i_next;
  logic          cmp_valid, cmp_valid_next;
  logic [IW-1:0] cmp_slot, cmp_slot_next;
  logic [4:0]    capacity;
  logic [CW-1:0] cap_eff;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;

  logic    res_load;
  result_t res_next;
  logic    can_start, match;

  function automatic logic [IW-1:0] wrap(input logic [CW:0] s);
    logic [CW:0] r;
    r = (s >= (CW+1)'(QUEUE_DEPTH)) ? s - (CW+1)'(QUEUE_DEPTH) : s;
    return r[IW-1:0];
  endfunction

  cip_ram #(.WIDTH($bits(entry_t)), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign cap_eff   = (32'(capacity) > QUEUE_DEPTH) ? CW'(QUEUE_DEPTH) : CW'(capacity);
  assign can_start = !out_valid || out_ready;
  assign match = (ram_rdata.low_key == cur.entry.low_key) &&
                 (ram_rdata.high_key == cur.entry.high_key) &&
                 (ram_rdata.cell_x == cur.entry.cell_x) &&
                 (ram_rdata.cell_y == cur.entry.cell_y) &&
                 (ram_rdata.cell_z == cur.entry.cell_z);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid && can_start) begin
          if (item.command == CMD_POP && occ != '0) begin
            state_next = ST_POP;
          end else if (item.command == CMD_ENQUEUE &&
                       item.entry.src_id != 64'd0 && cap_eff != '0) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cmp_valid && match) begin
          state_next = ST_IDLE;
        end else if (rd_i >= occ && !cmp_valid) begin
          state_next = ST_IDLE;
        end
      end
      ST_POP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    item_pop       = 1'b0;
    cur_next       = cur;
    head_next      = head;
    occ_next       = occ;
    rd_i_next      = rd_i;
    cmp_valid_next = 1'b0;
    cmp_slot_next  = cmp_slot;
    ram_we         = 1'b0;
    ram_waddr      = cmp_slot;
    ram_wdata      = cur.entry;
    ram_re         = 1'b0;
    ram_raddr      = head;
    res_load       = 1'b0;
    res_next       = '0;
    case (state)
      ST_IDLE: begin
        if (item_valid && can_start) begin
          item_pop  = 1'b1;
          cur_next  = item;
          rd_i_next = '0;
          case (item.command)
            CMD_POP: begin
              if (occ != '0) begin
                ram_re = 1'b1;
              end else begin
                res_load = 1'b1;
              end
            end
            CMD_CLEAR: begin
              occ_next  = '0;
              head_next = '0;
              res_load  = 1'b1;
            end
            CMD_ENQUEUE: begin
              if (item.entry.src_id == 64'd0 || cap_eff == '0) begin
                res_load = 1'b1;
              end
            end
            default: res_load = 1'b1;
          endcase
          res_next.entry_count = 5'(occ_next);
        end
      end
      ST_SCAN: begin
        // compare is done in the cycle after its read
        if (cmp_valid && match) begin
          if ($signed(cur.entry.impulse) > $signed(ram_rdata.impulse)) begin
            ram_we = 1'b1;
          end
          res_load = 1'b1;
        end else if (rd_i < occ) begin
          ram_re         = 1'b1;
          ram_raddr      = wrap({1'b0, CW'(head)} + {1'b0, rd_i});
          rd_i_next      = rd_i + 1'b1;
          cmp_valid_next = 1'b1;
          cmp_slot_next  = ram_raddr;
        end else if (!cmp_valid) begin
          res_load = 1'b1;
          if (occ < cap_eff) begin
            ram_we            = 1'b1;
            ram_waddr         = wrap({1'b0, CW'(head)} + {1'b0, occ});
            occ_next          = occ + 1'b1;
            res_next.accepted = 1'b1;
          end
        end
        res_next.entry_count = 5'(occ_next);
      end
      ST_POP: begin
        res_load              = 1'b1;
        res_next.pop_valid    = 1'b1;
        res_next.src_id       = ram_rdata.src_id;
        res_next.tgt_id       = ram_rdata.tgt_id;
        res_next.col_id       = ram_rdata.col_id;
        res_next.point_x      = ram_rdata.point_x;
        res_next.point_y      = ram_rdata.point_y;
        res_next.point_z      = ram_rdata.point_z;
        res_next.impulse      = ram_rdata.impulse;
        res_next.speed        = ram_rdata.speed;
        head_next             = wrap({1'b0, CW'(head)} + (CW+1)'(1));
        occ_next              = occ - 1'b1;
        res_next.entry_count  = 5'(occ_next);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      occ       <= '0;
      cmp_valid <= 1'b0;
      capacity  <= 5'd16;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      occ       <= occ_next;
      cmp_valid <= cmp_valid_next;
      if (cfg_we) capacity <= cfg_wdata;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    cur      <= cur_next;
    rd_i     <= rd_i_next;
    cmp_slot <= cmp_slot_next;
    if (res_load) begin
      out_result <= res_next;
    end
  end
endmodule

/* rtl/coalescing_impact_queue_top.sv */
// Top level of the coalescing impact queue: stream ports and config write.
// Depends on cip_pkg, cip_front, cip_fifo, cip_back.

// A bounded FIFO of impact records that merges entries with the same
// unordered ID pair and 350 mm spatial cell, keeping the stronger impulse.
// Each input word yields one output word. The front end has one register
// stage (the key and cells are formed behind it) and feeds a two-word queue;
// for an enqueue the back end sequencer then reads one stored key from the
// entry RAM per cycle, compares it in the cycle after its read, ends the
// scan on a match and otherwise appends if there is room. A pop of a
// nonempty queue reads the head entry and then outputs it; clear, an empty
// pop, a rejected enqueue or an unused command are answered directly from
// the idle state.
module coalescing_impact_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata,     // capacity_limit
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // source, target, collider ids, point_x, point_y, point_z, impulse, speed
  input  logic [327:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,  // command
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out source, target, collider ids, out_point_x, out_point_y,
  // out_point_z, out_impulse, out_speed, entry_count, zero pad
  output logic [335:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser   // accepted, pop_valid
);
  import cip_pkg::*;

  logic    push, push_ready, q_valid, q_pop;
  item_t   push_item, q_item;
  result_t res;

  cip_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_command    (cmd_t'(s_axis_tuser)),
    .in_src_id     (s_axis_tdata[63:0]),
    .in_tgt_id     (s_axis_tdata[127:64]),
    .in_col_id     (s_axis_tdata[191:128]),
    .in_point_x    (s_axis_tdata[215:192]),
    .in_point_y    (s_axis_tdata[239:216]),
    .in_point_z    (s_axis_tdata[263:240]),
    .in_impulse    (s_axis_tdata[295:264]),
    .in_speed      (s_axis_tdata[327:296]),
    .push          (push),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  cip_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_ready(push_ready),
    .wr_item (push_item),
    .rd_valid(q_valid),
    .rd_en   (q_pop),
    .rd_item (q_item)
  );

  cip_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item_valid(q_valid),
    .item_pop  (q_pop),
    .item      (q_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_result(res)
  );

  assign m_axis_tuser = {res.pop_valid, res.accepted};
  assign m_axis_tdata = {3'b000, res.entry_count, res.speed, res.impulse,
                         res.point_z, res.point_y, res.point_x,
                         res.col_id, res.tgt_id, res.src_id};
endmodule
